/* rtl/core/tld_pkg.sv */
package tld_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] group_t;
    typedef logic [6:0]  limit_t;
    typedef logic [1:0]  cfg_idx_t;

    // Command codes of an input item
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Register indexes of the configuration port
    localparam cfg_idx_t CFG_CANONICAL = 2'd0;
    localparam cfg_idx_t CFG_ECHO      = 2'd1;
    localparam cfg_idx_t CFG_SIGNAL    = 2'd2;
    localparam cfg_idx_t CFG_GROUP     = 2'd3;

    // Special bytes
    localparam byte_t BYTE_INTR = 8'h03;
    localparam byte_t BYTE_BS   = 8'h08;
    localparam byte_t BYTE_NL   = 8'h0A;

    // One result item
    typedef struct packed {
        logic   echo_valid;
        byte_t  echo_byte;
        logic   interrupt_request;
        group_t signal_group;
        logic   wake_reader;
        logic   data_valid;
        byte_t  data_byte;
        logic   last;
    } item_t;

endpackage

/* rtl/core/terminal_line_discipline_unit.sv */
// A received byte gives its result in the cycle after acceptance; erasing a stored byte
// in canonical mode first does one ring read to check for a newline, then gives its result.
// A read request first fetches from the ring, then gives one byte per cycle from the ring
// memory's read port unless the output stalls; an empty read answers in the next cycle.
// One item is in work at a time; the next is taken at the edge its last result leaves.
// Reset clears pointers and counts and loads register defaults; ring contents stay undefined.
module terminal_line_discipline_unit #(
    parameter int RING_DEPTH = 256,
    parameter int MAX_READ   = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  tld_pkg::cfg_idx_t   cfg_index,
    input  tld_pkg::group_t     cfg_data,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  tld_pkg::byte_t      in_byte,
    input  tld_pkg::limit_t     read_limit,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                echo_valid,
    output tld_pkg::byte_t      echo_byte,
    output logic                interrupt_request,
    output tld_pkg::group_t     signal_group,
    output logic                wake_reader,
    output logic                data_valid,
    output tld_pkg::byte_t      data_byte,
    output logic                last
);
    import tld_pkg::*;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FILL_MAX  = CNT_W'(RING_DEPTH);
    localparam limit_t            LIMIT_MAX = 7'(MAX_READ);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERASE,
        ST_READ
    } state_t;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        return (p == ADDR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
        return (p == '0) ? ADDR_LAST : p - 1'b1;
    endfunction

    // control and output registers
    state_t             state_reg,  state_next;
    logic [ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg,   fill_next;
    logic [CNT_W-1:0]   nl_reg,     nl_next;
    limit_t             limit_reg,  limit_next;
    limit_t             cnt_reg,    cnt_next;
    logic               canon_reg,  canon_next;
    logic               echo_reg,   echo_next;
    logic               sig_reg,    sig_next;
    group_t             group_reg,  group_next;
    logic               ovalid_reg, ovalid_next;
    item_t              item_reg,   item_next;

    // ring memory
    byte_t              ring_mem [RING_DEPTH];
    byte_t              rd_q;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;

    logic               out_free;
    logic               in_accept;

    assign out_free  = !ovalid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;

    // next-state logic
    always_comb
    begin
        limit_t            lim;
        logic              done;
        logic [CNT_W-1:0]  fill_dec;

        state_next  = state_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        nl_next     = nl_reg;
        limit_next  = limit_reg;
        cnt_next    = cnt_reg;
        canon_next  = canon_reg;
        echo_next   = echo_reg;
        sig_next    = sig_reg;
        group_next  = group_reg;
        ovalid_next = ovalid_reg;
        item_next   = item_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = wr_ptr_reg;
        mem_raddr   = rd_ptr_reg;
        lim         = (read_limit > LIMIT_MAX) ? LIMIT_MAX : read_limit;
        fill_dec    = fill_reg - 1'b1;
        done        = 1'b0;

        // result taken downstream
        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        // register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CANONICAL: canon_next = cfg_data[0];
                CFG_ECHO:      echo_next  = cfg_data[0];
                CFG_SIGNAL:    sig_next   = cfg_data[0];
                CFG_GROUP:     group_next = cfg_data;
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    item_next      = '0;
                    item_next.last = 1'b1;
                    if (command == CMD_READ)
                    begin
                        limit_next = lim;
                        cnt_next   = '0;
                        if (lim == '0 || fill_reg == '0 || (canon_reg && nl_reg == '0))
                        begin
                            ovalid_next = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = rd_ptr_reg;
                            state_next = ST_READ;
                        end
                    end
                    else if (sig_reg && in_byte == BYTE_INTR)
                    begin
                        item_next.interrupt_request = 1'b1;
                        item_next.signal_group      = group_reg;
                        ovalid_next                 = 1'b1;
                    end
                    else if (canon_reg && in_byte == BYTE_BS)
                    begin
                        if (fill_reg == '0)
                        begin
                            ovalid_next = 1'b1;
                        end
                        else
                        begin
                            // fetch the newest byte to see if it was a newline
                            wr_ptr_next = ptr_dec(wr_ptr_reg);
                            fill_next   = fill_dec;
                            mem_re      = 1'b1;
                            mem_raddr   = ptr_dec(wr_ptr_reg);
                            state_next  = ST_ERASE;
                        end
                    end
                    else
                    begin
                        // store unless full; echo and wake regardless
                        if (fill_reg < FILL_MAX)
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            fill_next   = fill_reg + 1'b1;
                            if (in_byte == BYTE_NL)
                            begin
                                nl_next = nl_reg + 1'b1;
                            end
                        end
                        item_next.echo_valid  = echo_reg;
                        item_next.echo_byte   = echo_reg ? in_byte : '0;
                        item_next.wake_reader = canon_reg ? (in_byte == BYTE_NL) : 1'b1;
                        ovalid_next           = 1'b1;
                    end
                end
            end

            ST_ERASE:
            begin
                if (out_free)
                begin
                    if (rd_q == BYTE_NL && nl_reg != '0)
                    begin
                        nl_next = nl_reg - 1'b1;
                    end
                    item_next            = '0;
                    item_next.last       = 1'b1;
                    item_next.echo_valid = echo_reg;
                    item_next.echo_byte  = echo_reg ? BYTE_BS : '0;
                    ovalid_next          = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    fill_next   = fill_dec;
                    cnt_next    = cnt_reg + 1'b1;
                    if (rd_q == BYTE_NL && nl_reg != '0)
                    begin
                        nl_next = nl_reg - 1'b1;
                    end
                    done = (cnt_reg + 1'b1 == limit_reg) || (fill_dec == '0) ||
                           (canon_reg && rd_q == BYTE_NL);
                    item_next            = '0;
                    item_next.data_valid = 1'b1;
                    item_next.data_byte  = rd_q;
                    item_next.last       = done;
                    ovalid_next          = 1'b1;
                    if (done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // prefetch the following byte
                        mem_re    = 1'b1;
                        mem_raddr = ptr_inc(rd_ptr_reg);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            nl_reg     <= '0;
            limit_reg  <= '0;
            cnt_reg    <= '0;
            canon_reg  <= 1'b1;
            echo_reg   <= 1'b1;
            sig_reg    <= 1'b1;
            group_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            nl_reg     <= nl_next;
            limit_reg  <= limit_next;
            cnt_reg    <= cnt_next;
            canon_reg  <= canon_next;
            echo_reg   <= echo_next;
            sig_reg    <= sig_next;
            group_reg  <= group_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    // ring memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= in_byte;
        end
        if (mem_re)
        begin
            rd_q <= ring_mem[mem_raddr];
        end
    end

    assign out_valid         = ovalid_reg;
    assign echo_valid        = item_reg.echo_valid;
    assign echo_byte         = item_reg.echo_byte;
    assign interrupt_request = item_reg.interrupt_request;
    assign signal_group      = item_reg.signal_group;
    assign wake_reader       = item_reg.wake_reader;
    assign data_valid        = item_reg.data_valid;
    assign data_byte         = item_reg.data_byte;
    assign last              = item_reg.last;

`ifndef NO_ASSERTIONS
    // unread newlines never outnumber unread bytes; an erase settles the count on leaving
    a_nl_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ERASE) |-> (nl_reg <= fill_reg))
        else $error("newline count exceeds fill");

    // fill stays within the ring
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill beyond ring depth");

    // a read in progress has bytes left and has not reached its limit
    a_read_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (fill_reg != '0 && cnt_reg < limit_reg))
        else $error("read past data or limit");

    // data results carry no byte-path flags
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && item_reg.data_valid) |->
            (!item_reg.echo_valid && !item_reg.interrupt_request && !item_reg.wake_reader))
        else $error("data result with byte-path flags");

    // a finished read or erase always leaves a result behind
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_next == ST_IDLE) |=> ovalid_reg && item_reg.last)
        else $error("item ended without a last result");
`endif

endmodule

/* verif/tb_terminal_line_discipline_unit.sv */
module tb_terminal_line_discipline_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tld_pkg::*;

    localparam int RING_DEPTH = 256;
    localparam int MAX_READ   = 64;
    localparam int IDLE_GAP   = 4;          // cycles after the last result before a reg write
    localparam int RUN_LIMIT  = 50_000_000; // ns, watchdog

    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

    // One step of the directed plan: an item (optionally with a typed-in result) or a reg write
    typedef struct packed {
        row_kind_t kind;
        logic      cmd;
        byte_t     in_b;
        limit_t    lim;
        bit        typed;
        item_t     want;
        cfg_idx_t  idx;
        group_t    val;
    } plan_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_we = 1'b0;
    cfg_idx_t cfg_index = CFG_CANONICAL;
    group_t   cfg_data = '0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    logic     command = CMD_BYTE;
    byte_t    in_byte = '0;
    limit_t   read_limit = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    logic     echo_valid;
    byte_t    echo_byte;
    logic     interrupt_request;
    group_t   signal_group;
    logic     wake_reader;
    logic     data_valid;
    byte_t    data_byte;
    logic     last;

    // Shadow of the discipline state and registers
    byte_t      ring_copy [RING_DEPTH];
    logic [8:0] wr_ptr;
    logic [8:0] rd_ptr;
    int         nl_count;
    bit         canon_on;
    bit         echo_on;
    bit         intr_on;
    group_t     fg_group;

    item_t     step_results [$];
    item_t     due_results [$];
    plan_row_t directed_plan [$];

    bit quiet = 1'b0;
    int stall_left = 0;
    int mismatches = 0;
    int items_taken = 0;
    int reads_taken = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int bytes_dropped = 0;

    terminal_line_discipline_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .in_byte           (in_byte),
        .read_limit        (read_limit),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .echo_valid        (echo_valid),
        .echo_byte         (echo_byte),
        .interrupt_request (interrupt_request),
        .signal_group      (signal_group),
        .wake_reader       (wake_reader),
        .data_valid        (data_valid),
        .data_byte         (data_byte),
        .last              (last)
    );

    always #10 clk = ~clk;

    function automatic item_t pack_result(logic ev, byte_t eb, logic ir, group_t sg,
                                          logic wk, logic dv, byte_t db, logic lst);
        item_t r;
        r.echo_valid        = ev;
        r.echo_byte         = eb;
        r.interrupt_request = ir;
        r.signal_group      = sg;
        r.wake_reader       = wk;
        r.data_valid        = dv;
        r.data_byte         = db;
        r.last              = lst;
        return r;
    endfunction

    // Expected results of one accepted item, appended to step_results
    function automatic void apply_line_discipline(logic cmd, byte_t b, limit_t lim);
        logic [8:0] used;
        int         budget;
        int         n;
        byte_t      c;
        bit         erased;
        bit         wk;
        item_t      tail;
        used = wr_ptr - rd_ptr;
        if (cmd == CMD_BYTE) begin
            if (intr_on && b == BYTE_INTR) begin
                step_results.push_back(pack_result(0, 0, 1, fg_group, 0, 0, 0, 1));
            end
            else if (canon_on && b == BYTE_BS) begin
                // erase the newest unread byte, newline included
                erased = 1'b0;
                if (used != 0) begin
                    wr_ptr = wr_ptr - 9'd1;
                    if (ring_copy[wr_ptr[7:0]] == BYTE_NL && nl_count > 0)
                        nl_count--;
                    erased = 1'b1;
                end
                if (erased && echo_on)
                    step_results.push_back(pack_result(1, BYTE_BS, 0, 0, 0, 0, 0, 1));
                else
                    step_results.push_back(pack_result(0, 0, 0, 0, 0, 0, 0, 1));
            end
            else begin
                // store unless full; echo and wake regardless
                if (used < RING_DEPTH) begin
                    ring_copy[wr_ptr[7:0]] = b;
                    wr_ptr = wr_ptr + 9'd1;
                    if (b == BYTE_NL)
                        nl_count++;
                end
                else begin
                    bytes_dropped++;
                end
                wk = canon_on ? (b == BYTE_NL) : 1'b1;
                step_results.push_back(pack_result(echo_on, echo_on ? b : 8'h00, 0, 0,
                                                   wk, 0, 0, 1));
            end
        end
        else begin
            budget = (lim > MAX_READ) ? MAX_READ : int'(lim);
            n = 0;
            if (!canon_on || nl_count > 0) begin
                while (n < budget && wr_ptr != rd_ptr) begin
                    c = ring_copy[rd_ptr[7:0]];
                    rd_ptr = rd_ptr + 9'd1;
                    step_results.push_back(pack_result(0, 0, 0, 0, 0, 1, c, 0));
                    n++;
                    if (c == BYTE_NL) begin
                        if (nl_count > 0)
                            nl_count--;
                        if (canon_on)
                            break;
                    end
                end
            end
            if (n == 0) begin
                step_results.push_back(pack_result(0, 0, 0, 0, 0, 0, 0, 1));
            end
            else begin
                tail = step_results.pop_back();
                tail.last = 1'b1;
                step_results.push_back(tail);
            end
        end
    endfunction

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatches < 40)
            $display("MISMATCH at result %0d: %s got %0h want %0h",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    function automatic void add_item(logic cmd, byte_t b, limit_t lim, bit typed, item_t want);
        plan_row_t r;
        r = '0;
        r.kind  = ROW_ITEM;
        r.cmd   = cmd;
        r.in_b  = b;
        r.lim   = lim;
        r.typed = typed;
        r.want  = want;
        directed_plan.push_back(r);
    endfunction

    function automatic void add_reg(cfg_idx_t idx, group_t val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        directed_plan.push_back(r);
    endfunction

    // Offer one item, with an occasional gap before it, and book its results
    task automatic feed_item(logic cmd, byte_t b, limit_t lim, bit typed, item_t want);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        in_byte    <= b;
        read_limit <= lim;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        step_results.delete();
        apply_line_discipline(cmd, b, lim);
        if (typed)
            due_results.push_back(want);
        else
            foreach (step_results[i])
                due_results.push_back(step_results[i]);
        items_taken++;
        if (cmd == CMD_READ)
            reads_taken++;
    endtask

    // Drain everything outstanding, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, group_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CANONICAL: canon_on = val[0];
            CFG_ECHO:      echo_on  = val[0];
            CFG_SIGNAL:    intr_on  = val[0];
            CFG_GROUP:     fg_group = val;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // Receiver back-pressure in random bursts
    always @(posedge clk) begin
        if (quiet) begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // Result checker: compare against the oldest expectation
    always @(posedge clk) begin : result_check
        item_t got;
        item_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = pack_result(echo_valid, echo_byte, interrupt_request, signal_group,
                              wake_reader, data_valid, data_byte, last);
            if (due_results.size() == 0) begin
                flag_mismatch("unexpected result", 32'(got.data_byte), 0);
            end
            else begin
                want = due_results.pop_front();
                if (got.echo_valid !== want.echo_valid)
                    flag_mismatch("echo_valid", 32'(got.echo_valid), 32'(want.echo_valid));
                if (got.echo_byte !== want.echo_byte)
                    flag_mismatch("echo_byte", 32'(got.echo_byte), 32'(want.echo_byte));
                if (got.interrupt_request !== want.interrupt_request)
                    flag_mismatch("interrupt_request", 32'(got.interrupt_request),
                                  32'(want.interrupt_request));
                if (got.signal_group !== want.signal_group)
                    flag_mismatch("signal_group", 32'(got.signal_group),
                                  32'(want.signal_group));
                if (got.wake_reader !== want.wake_reader)
                    flag_mismatch("wake_reader", 32'(got.wake_reader), 32'(want.wake_reader));
                if (got.data_valid !== want.data_valid)
                    flag_mismatch("data_valid", 32'(got.data_valid), 32'(want.data_valid));
                if (got.data_byte !== want.data_byte)
                    flag_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
                if (got.last !== want.last)
                    flag_mismatch("last", 32'(got.last), 32'(want.last));
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        #RUN_LIMIT;
        $display("terminal_line_discipline_unit test failed");
        $finish;
    end

    initial begin : stimulus
        int    p;
        int    n;
        int    k;
        int    len;
        int    guard;
        byte_t b;

        // register defaults and empty ring after reset
        wr_ptr   = '0;
        rd_ptr   = '0;
        nl_count = 0;
        canon_on = 1'b1;
        echo_on  = 1'b1;
        intr_on  = 1'b1;
        fg_group = '0;

        // directed plan, canonical mode with echo and signals first
        add_reg(CFG_GROUP, 16'hFFFF);
        add_item(CMD_BYTE, BYTE_INTR, 7'd0, 1, pack_result(0, 0, 1, 16'hFFFF, 0, 0, 0, 1));
        add_item(CMD_READ, 8'h00, 7'd5, 1, pack_result(0, 0, 0, 0, 0, 0, 0, 1));
        add_item(CMD_BYTE, BYTE_BS, 7'd0, 1, pack_result(0, 0, 0, 0, 0, 0, 0, 1));
        add_item(CMD_BYTE, 8'h00, 7'd0, 1, pack_result(1, 8'h00, 0, 0, 0, 0, 0, 1));
        add_item(CMD_BYTE, 8'hFF, 7'd127, 1, pack_result(1, 8'hFF, 0, 0, 0, 0, 0, 1));
        add_item(CMD_BYTE, BYTE_BS, 7'd0, 1, pack_result(1, BYTE_BS, 0, 0, 0, 0, 0, 1));
        add_item(CMD_BYTE, 8'h61, 7'd0, 0, '0);
        add_item(CMD_BYTE, BYTE_NL, 7'd0, 1, pack_result(1, BYTE_NL, 0, 0, 1, 0, 0, 1));
        add_item(CMD_BYTE, 8'h62, 7'd0, 0, '0);
        add_item(CMD_BYTE, BYTE_BS, 7'd0, 0, '0);
        add_item(CMD_BYTE, BYTE_BS, 7'd0, 0, '0);   // erases the newline
        add_item(CMD_READ, 8'h00, 7'd64, 1, pack_result(0, 0, 0, 0, 0, 0, 0, 1));
        add_item(CMD_BYTE, BYTE_NL, 7'd0, 0, '0);
        add_item(CMD_BYTE, 8'h63, 7'd0, 0, '0);
        add_item(CMD_BYTE, BYTE_NL, 7'd0, 0, '0);
        add_item(CMD_READ, 8'hFF, 7'd127, 0, '0);   // saturates, stops at first newline
        add_item(CMD_READ, 8'h00, 7'd0, 1, pack_result(0, 0, 0, 0, 0, 0, 0, 1));
        add_item(CMD_READ, 8'h00, 7'd1, 0, '0);
        // raw mode, no echo, no signals
        add_reg(CFG_CANONICAL, 16'h0000);
        add_reg(CFG_ECHO, 16'h0000);
        add_reg(CFG_SIGNAL, 16'h0000);
        add_reg(CFG_GROUP, 16'h0000);
        add_item(CMD_BYTE, BYTE_INTR, 7'd0, 1, pack_result(0, 0, 0, 0, 1, 0, 0, 1));
        add_item(CMD_BYTE, BYTE_BS, 7'd0, 1, pack_result(0, 0, 0, 0, 1, 0, 0, 1));
        add_item(CMD_READ, 8'h00, 7'd63, 0, '0);    // newline does not stop a raw read
        add_item(CMD_READ, 8'h00, 7'd64, 1, pack_result(0, 0, 0, 0, 0, 0, 0, 1));
        // raw mode with echo and signals
        add_reg(CFG_ECHO, 16'hFFFF);
        add_reg(CFG_SIGNAL, 16'h0001);
        add_reg(CFG_GROUP, 16'h8001);
        add_item(CMD_BYTE, BYTE_INTR, 7'd0, 1, pack_result(0, 0, 1, 16'h8001, 0, 0, 0, 1));
        add_item(CMD_BYTE, 8'h7F, 7'd0, 1, pack_result(1, 8'h7F, 0, 0, 1, 0, 0, 1));
        add_item(CMD_READ, 8'h00, 7'd64, 0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < directed_plan.size(); i++) begin
            if (directed_plan[i].kind == ROW_REG) begin
                wait_idle();
                write_reg(directed_plan[i].idx, directed_plan[i].val);
            end
            else begin
                feed_item(directed_plan[i].cmd, directed_plan[i].in_b, directed_plan[i].lim,
                          directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // ring full: overfill in raw mode, erase and refill canonically, then drain
        wait_idle();
        write_reg(CFG_CANONICAL, 16'h0000);
        write_reg(CFG_SIGNAL, 16'h0000);
        repeat (RING_DEPTH + 4)
            feed_item(CMD_BYTE, byte_t'($urandom), limit_t'($urandom), 0, '0);
        wait_idle();
        write_reg(CFG_CANONICAL, 16'h0001);
        write_reg(CFG_SIGNAL, 16'h0001);
        repeat (3)
            feed_item(CMD_BYTE, BYTE_BS, limit_t'($urandom), 0, '0);
        repeat (4)
            feed_item(CMD_BYTE, byte_t'($urandom_range(8'h20, 8'h7E)), limit_t'($urandom),
                      0, '0);
        wait_idle();
        write_reg(CFG_CANONICAL, 16'h0000);
        repeat (5)
            feed_item(CMD_READ, byte_t'($urandom), 7'd64, 0, '0);

        // random phases over every mode combination; the last runs without idling
        for (p = 0; p < 8; p++) begin
            wait_idle();
            if (p == 7)
                quiet = 1'b1;
            write_reg(CFG_CANONICAL, (group_t'($urandom) & 16'hFFFE) | group_t'(p[0]));
            write_reg(CFG_ECHO, (group_t'($urandom) & 16'hFFFE) | group_t'(p[1]));
            write_reg(CFG_SIGNAL, (group_t'($urandom) & 16'hFFFE) | group_t'(p[2]));
            write_reg(CFG_GROUP, (p == 0) ? 16'h0000 : (p == 5) ? 16'hFFFF
                                                              : group_t'($urandom));
            n = 0;
            while (n < 2) begin
                k = $urandom_range(0, 9);
                if (k < 6) begin
                    // a typed line with some editing, usually closed, then a read
                    len = $urandom_range(0, 10);
                    repeat (len) begin
                        if ($urandom_range(0, 7) == 0)
                            b = BYTE_BS;
                        else if ($urandom_range(0, 5) == 0)
                            b = byte_t'($urandom);
                        else
                            b = byte_t'($urandom_range(8'h20, 8'h7E));
                        feed_item(CMD_BYTE, b, limit_t'($urandom), 0, '0);
                        n++;
                    end
                    if ($urandom_range(0, 5) != 0) begin
                        feed_item(CMD_BYTE, BYTE_NL, limit_t'($urandom), 0, '0);
                        n++;
                    end
                    feed_item(CMD_READ, byte_t'($urandom), limit_t'($urandom_range(1, 16)),
                              0, '0);
                    n++;
                end
                else if (k < 8) begin
                    feed_item(CMD_BYTE, byte_t'($urandom), limit_t'($urandom), 0, '0);
                    n++;
                end
                else begin
                    feed_item(CMD_READ, byte_t'($urandom), limit_t'($urandom_range(0, 127)),
                              0, '0);
                    n++;
                end
            end
        end

        // drain, then watch for stragglers
        in_valid <= 1'b0;
        guard = 0;
        while (due_results.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (due_results.size() != 0)
            flag_mismatch("results never arrived", unsigned'(due_results.size()), 0);

        $display("covered %0d items (%0d reads), %0d results, %0d register writes",
                 items_taken, reads_taken, results_seen, reg_writes);
        $display("all mode combinations visited, %0d bytes dropped on a full ring",
                 bytes_dropped);
        if (mismatches == 0)
            $display("terminal_line_discipline_unit test passed");
        else
            $display("terminal_line_discipline_unit test failed");
        $finish;
    end

endmodule

/* terminal_line_discipline_unit.f */
rtl/core/tld_pkg.sv
rtl/core/terminal_line_discipline_unit.sv
verif/tb_terminal_line_discipline_unit.sv
